// ----- rtl/ebalu_pkg.sv -----
// shared types, codes and constants of the 8-bit cpu alu
package ebalu_pkg;

    // flag bit positions in the 4-bit flag word
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // where a result is written
    typedef enum logic [1:0] {
        DEST_ACC     = 2'd0,
        DEST_OPERAND = 2'd1,
        DEST_WIDE    = 2'd2,
        DEST_FLAGS   = 2'd3
    } dest_kind_t;

    // 8-bit arithmetic block kinds, opcode bits 5:3
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBC = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CP  = 3'd7
    } alu_kind_t;

    // rotate and shift kinds, opcode bits 5:3 on the cb page
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } shift_kind_t;

    // cb page groups, opcode bits 7:6
    typedef enum logic [1:0] {
        CB_SHIFT = 2'd0,
        CB_BIT   = 2'd1,
        CB_RES   = 2'd2,
        CB_SET   = 2'd3
    } cb_group_t;

    // main page opcodes and opcode match patterns
    localparam logic [7:0] OP_DAA       = 8'h27;
    localparam logic [7:0] OP_CPL       = 8'h2F;
    localparam logic [7:0] OP_SCF       = 8'h37;
    localparam logic [7:0] OP_CCF       = 8'h3F;
    localparam logic [7:0] OP_ADD_SP    = 8'hE8;
    localparam logic [7:0] OP_LD_HL_SP  = 8'hF8;
    localparam logic [7:0] MASK_ADD_HL  = 8'hCF;
    localparam logic [7:0] PAT_ADD_HL   = 8'h09;
    localparam logic [7:0] MASK_INCDEC  = 8'hC7;
    localparam logic [7:0] PAT_INC      = 8'h04;
    localparam logic [7:0] PAT_DEC      = 8'h05;
    localparam logic [7:0] MASK_ROT_A   = 8'hE7;
    localparam logic [7:0] PAT_ROT_A    = 8'h07;
    localparam logic [7:0] MASK_ALU_REG = 8'hC0;
    localparam logic [7:0] PAT_ALU_REG  = 8'h80;
    localparam logic [7:0] PAT_ALU_IMM  = 8'hC6;

    // decimal adjust constants
    localparam logic [7:0] DAA_LIMIT_HI = 8'h99;
    localparam logic [3:0] DAA_LIMIT_LO = 4'h9;
    localparam logic [7:0] DAA_CORR_HI  = 8'h60;
    localparam logic [7:0] DAA_CORR_LO  = 8'h06;

    // one request as held in the input register
    typedef struct packed {
        logic [7:0]  op_code;
        logic        cb_page;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [3:0]  flags;
        logic [15:0] wide_left;
        logic [15:0] wide_right;
    } req_t;

    // one result as held in the output register
    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] word_result;
        logic [3:0]  flags;
        dest_kind_t  dest_kind;
        logic        not_alu_op;
    } res_t;

endpackage

// ----- rtl/eight_bit_cpu_alu_with_flags.sv -----
// top level of the 8-bit cpu alu: input register, alu logic, result register
// Arithmetic and flag unit of an 8-bit cpu. A request is captured in an input
// register, passes the alu logic (8-bit and 16-bit adders, rotates, bit ops,
// decimal adjust and flag logic) and lands in a result register, which drives
// the m_ ports; it moves on from the input register when the result register
// is empty or m_ready is high. One request is taken every clock cycle while the
// result port is not stalled; the two registers form a two-entry pipeline, and
// a new request is still accepted while a finished result waits for m_ready,
// as long as the input register is empty. Opcodes that are not arithmetic come
// back with m_not_alu_op set and the inputs passed through.
module eight_bit_cpu_alu_with_flags (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_op_code,
    input  logic        s_cb_page,
    input  logic [7:0]  s_acc_in,
    input  logic [7:0]  s_operand_in,
    input  logic [3:0]  s_flags_in,
    input  logic [15:0] s_wide_left,
    input  logic [15:0] s_wide_right,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_result,
    output logic [15:0] m_word_result,
    output logic [3:0]  m_flags_out,
    output logic [1:0]  m_dest_kind,
    output logic        m_not_alu_op
);

    logic            in_valid_reg;
    ebalu_pkg::req_t req_reg;
    logic            out_valid_reg;
    ebalu_pkg::res_t res_reg;
    ebalu_pkg::res_t res_next;
    logic            advance;

    // alu logic between the two registers
    ebalu_core u_core (
        .req (req_reg),
        .res (res_next)
    );

    // pipeline flow control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.op_code    <= s_op_code;
            req_reg.cb_page    <= s_cb_page;
            req_reg.acc        <= s_acc_in;
            req_reg.operand    <= s_operand_in;
            req_reg.flags      <= s_flags_in;
            req_reg.wide_left  <= s_wide_left;
            req_reg.wide_right <= s_wide_right;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // result port
    assign m_valid       = out_valid_reg;
    assign m_byte_result = res_reg.byte_result;
    assign m_word_result = res_reg.word_result;
    assign m_flags_out   = res_reg.flags;
    assign m_dest_kind   = res_reg.dest_kind;
    assign m_not_alu_op  = res_reg.not_alu_op;

endmodule

// ----- rtl/ebalu_core.sv -----
// opcode decode, 8/16-bit adders, rotates, bit ops and flag logic
module ebalu_core (
    input  ebalu_pkg::req_t req,
    output ebalu_pkg::res_t res
);

    // rotate/shift helper: returns {carry out, result}
    function automatic logic [8:0] shift_op(input logic [2:0] kind, input logic [7:0] v,
                                            input logic cin);
        logic [8:0] r;
        case (ebalu_pkg::shift_kind_t'(kind))
            ebalu_pkg::SH_RLC:  r = {v[7], v[6:0], v[7]};
            ebalu_pkg::SH_RRC:  r = {v[0], v[0], v[7:1]};
            ebalu_pkg::SH_RL:   r = {v[7], v[6:0], cin};
            ebalu_pkg::SH_RR:   r = {v[0], cin, v[7:1]};
            ebalu_pkg::SH_SLA:  r = {v[7], v[6:0], 1'b0};
            ebalu_pkg::SH_SRA:  r = {v[0], v[7], v[7:1]};
            ebalu_pkg::SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
            default:            r = {v[0], 1'b0, v[7:1]};
        endcase
        return r;
    endfunction

    logic [7:0]  op;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [3:0]  f;
    logic [2:0]  sel;
    ebalu_pkg::alu_kind_t alu_kind;

    logic        alu_cin;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  dif9;
    logic [4:0]  hdif5;
    logic [7:0]  alu_r;
    logic [3:0]  alu_f;

    logic [8:0]  cb_shift;
    logic [8:0]  a_shift;
    logic [7:0]  inc_r;
    logic [7:0]  dec_r;
    logic [16:0] hl_sum;
    logic [12:0] hl_half;
    logic [15:0] sp_sum;
    logic [4:0]  sp_half;
    logic [8:0]  sp_low;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_corr;
    logic [7:0]  daa_r;
    logic [7:0]  bit_mask;

    assign op  = req.op_code;
    assign a   = req.acc;
    assign v   = req.operand;
    assign f   = req.flags;
    assign sel = op[5:3];
    assign alu_kind = ebalu_pkg::alu_kind_t'(sel);

    // 8-bit arithmetic block adders
    always_comb begin
        alu_cin = ((alu_kind == ebalu_pkg::ALU_ADC) || (alu_kind == ebalu_pkg::ALU_SBC))
                  ? f[ebalu_pkg::FLAG_C] : 1'b0;
        sum9  = {1'b0, a} + {1'b0, v} + {8'd0, alu_cin};
        hsum5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, alu_cin};
        dif9  = {1'b0, a} - {1'b0, v} - {8'd0, alu_cin};
        hdif5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, alu_cin};
        case (alu_kind)
            ebalu_pkg::ALU_ADD, ebalu_pkg::ALU_ADC: begin
                alu_r = sum9[7:0];
                alu_f = {1'b0, 1'b0, hsum5[4], sum9[8]};
            end
            ebalu_pkg::ALU_SUB, ebalu_pkg::ALU_SBC, ebalu_pkg::ALU_CP: begin
                alu_r = dif9[7:0];
                alu_f = {1'b0, 1'b1, hdif5[4], dif9[8]};
            end
            ebalu_pkg::ALU_AND: begin
                alu_r = a & v;
                alu_f = 4'b0010;
            end
            ebalu_pkg::ALU_XOR: begin
                alu_r = a ^ v;
                alu_f = 4'b0000;
            end
            default: begin
                alu_r = a | v;
                alu_f = 4'b0000;
            end
        endcase
        alu_f[ebalu_pkg::FLAG_Z] = (alu_r == 8'd0);
    end

    // shared helpers for the other ops
    always_comb begin
        cb_shift = shift_op(sel, v, f[ebalu_pkg::FLAG_C]);
        a_shift  = shift_op({1'b0, op[4:3]}, a, f[ebalu_pkg::FLAG_C]);
        inc_r    = v + 8'd1;
        dec_r    = v - 8'd1;
        hl_sum   = {1'b0, req.wide_left} + {1'b0, req.wide_right};
        hl_half  = {1'b0, req.wide_left[11:0]} + {1'b0, req.wide_right[11:0]};
        sp_sum   = req.wide_left + {{8{v[7]}}, v};
        sp_half  = {1'b0, req.wide_left[3:0]} + {1'b0, v[3:0]};
        sp_low   = {1'b0, req.wide_left[7:0]} + {1'b0, v};
        bit_mask = 8'd1 << sel;
        daa_lo   = f[ebalu_pkg::FLAG_H] ||
                   (!f[ebalu_pkg::FLAG_N] && (a[3:0] > ebalu_pkg::DAA_LIMIT_LO));
        daa_hi   = f[ebalu_pkg::FLAG_C] ||
                   (!f[ebalu_pkg::FLAG_N] && (a > ebalu_pkg::DAA_LIMIT_HI));
        daa_corr = (daa_lo ? ebalu_pkg::DAA_CORR_LO : 8'd0) |
                   (daa_hi ? ebalu_pkg::DAA_CORR_HI : 8'd0);
        daa_r    = f[ebalu_pkg::FLAG_N] ? (a - daa_corr) : (a + daa_corr);
    end

    // opcode decode and result select
    always_comb begin
        res.byte_result = a;
        res.word_result = req.wide_left;
        res.flags       = f;
        res.dest_kind   = ebalu_pkg::DEST_FLAGS;
        res.not_alu_op  = 1'b0;
        if (req.cb_page) begin
            case (ebalu_pkg::cb_group_t'(op[7:6]))
                ebalu_pkg::CB_SHIFT: begin
                    res.byte_result = cb_shift[7:0];
                    res.flags       = {(cb_shift[7:0] == 8'd0), 1'b0, 1'b0, cb_shift[8]};
                    res.dest_kind   = ebalu_pkg::DEST_OPERAND;
                end
                ebalu_pkg::CB_BIT: begin
                    res.byte_result = v;
                    res.flags       = {~v[sel], 1'b0, 1'b1, f[ebalu_pkg::FLAG_C]};
                end
                ebalu_pkg::CB_RES: begin
                    res.byte_result = v & ~bit_mask;
                    res.dest_kind   = ebalu_pkg::DEST_OPERAND;
                end
                default: begin
                    res.byte_result = v | bit_mask;
                    res.dest_kind   = ebalu_pkg::DEST_OPERAND;
                end
            endcase
        end else if ((op & ebalu_pkg::MASK_ADD_HL) == ebalu_pkg::PAT_ADD_HL) begin
            res.word_result = hl_sum[15:0];
            res.flags       = {f[ebalu_pkg::FLAG_Z], 1'b0, hl_half[12], hl_sum[16]};
            res.dest_kind   = ebalu_pkg::DEST_WIDE;
        end else if ((op & ebalu_pkg::MASK_INCDEC) == ebalu_pkg::PAT_INC) begin
            res.byte_result = inc_r;
            res.flags       = {(inc_r == 8'd0), 1'b0, (v[3:0] == 4'hF), f[ebalu_pkg::FLAG_C]};
            res.dest_kind   = ebalu_pkg::DEST_OPERAND;
        end else if ((op & ebalu_pkg::MASK_INCDEC) == ebalu_pkg::PAT_DEC) begin
            res.byte_result = dec_r;
            res.flags       = {(dec_r == 8'd0), 1'b1, (v[3:0] == 4'h0), f[ebalu_pkg::FLAG_C]};
            res.dest_kind   = ebalu_pkg::DEST_OPERAND;
        end else if ((op & ebalu_pkg::MASK_ROT_A) == ebalu_pkg::PAT_ROT_A) begin
            res.byte_result = a_shift[7:0];
            res.flags       = {3'b000, a_shift[8]};
            res.dest_kind   = ebalu_pkg::DEST_ACC;
        end else if (op == ebalu_pkg::OP_DAA) begin
            res.byte_result = daa_r;
            res.flags       = {(daa_r == 8'd0), f[ebalu_pkg::FLAG_N], 1'b0,
                               f[ebalu_pkg::FLAG_C] | daa_hi};
            res.dest_kind   = ebalu_pkg::DEST_ACC;
        end else if (op == ebalu_pkg::OP_CPL) begin
            res.byte_result = ~a;
            res.flags       = {f[ebalu_pkg::FLAG_Z], 1'b1, 1'b1, f[ebalu_pkg::FLAG_C]};
            res.dest_kind   = ebalu_pkg::DEST_ACC;
        end else if (op == ebalu_pkg::OP_SCF) begin
            res.flags       = {f[ebalu_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
        end else if (op == ebalu_pkg::OP_CCF) begin
            res.flags       = {f[ebalu_pkg::FLAG_Z], 1'b0, 1'b0, ~f[ebalu_pkg::FLAG_C]};
        end else if (((op & ebalu_pkg::MASK_ALU_REG) == ebalu_pkg::PAT_ALU_REG) ||
                     ((op & ebalu_pkg::MASK_INCDEC) == ebalu_pkg::PAT_ALU_IMM)) begin
            res.flags = alu_f;
            if (alu_kind != ebalu_pkg::ALU_CP) begin
                res.byte_result = alu_r;
                res.dest_kind   = ebalu_pkg::DEST_ACC;
            end
        end else if ((op == ebalu_pkg::OP_ADD_SP) || (op == ebalu_pkg::OP_LD_HL_SP)) begin
            res.word_result = sp_sum;
            res.flags       = {1'b0, 1'b0, sp_half[4], sp_low[8]};
            res.dest_kind   = ebalu_pkg::DEST_WIDE;
        end else begin
            res.not_alu_op  = 1'b1;
        end
    end

endmodule

// ----- rtl/ebalu_checker.sv -----
// port checker for the 8-bit cpu alu and its bind to the top level
module ebalu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_byte_result,
    input logic [15:0] m_word_result,
    input logic [3:0]  m_flags_out,
    input logic [1:0]  m_dest_kind,
    input logic        m_not_alu_op
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_result) &&
        $stable(m_word_result) && $stable(m_flags_out) && $stable(m_dest_kind))
        else $error("stalled result changed");

    // a non-arithmetic opcode writes nothing but the flags
    a_bad_op_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_not_alu_op |-> m_dest_kind == ebalu_pkg::DEST_FLAGS)
        else $error("non-alu opcode with a register destination");

    // 16-bit sums always clear the subtract flag
    a_wide_no_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dest_kind == ebalu_pkg::DEST_WIDE |->
        !m_flags_out[ebalu_pkg::FLAG_N] && !m_not_alu_op)
        else $error("wide result with subtract flag set");

endmodule

bind eight_bit_cpu_alu_with_flags ebalu_checker u_ebalu_checker (.*);

// ----- tb/eight_bit_cpu_alu_with_flags_tb.sv -----
// self-checking testbench for the 8-bit cpu alu: directed table, random requests, flag prediction
module eight_bit_cpu_alu_with_flags_tb;
    import ebalu_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int RAND_ITEMS      = 400;
    localparam int HOLD_CYCLES     = 64;
    localparam int DRAIN_CYCLES    = 8;

    // register fields of opcodes used in the directed table
    localparam logic [2:0] REG_B      = 3'd0;
    localparam logic [2:0] REG_HL_MEM = 3'd6;
    localparam logic [2:0] REG_A      = 3'd7;
    localparam logic [1:0] RR_HL      = 2'd2;

    // directed opcodes, built from the package patterns where one fits
    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_UNUSED   = 8'hD3;
    localparam logic [7:0] OP_ADD_B    = {PAT_ALU_REG[7:6], ALU_ADD, REG_B};
    localparam logic [7:0] OP_ADC_A    = {PAT_ALU_REG[7:6], ALU_ADC, REG_A};
    localparam logic [7:0] OP_SUB_B    = {PAT_ALU_REG[7:6], ALU_SUB, REG_B};
    localparam logic [7:0] OP_SBC_B    = {PAT_ALU_REG[7:6], ALU_SBC, REG_B};
    localparam logic [7:0] OP_AND_B    = {PAT_ALU_REG[7:6], ALU_AND, REG_B};
    localparam logic [7:0] OP_XOR_A    = {PAT_ALU_REG[7:6], ALU_XOR, REG_A};
    localparam logic [7:0] OP_OR_B     = {PAT_ALU_REG[7:6], ALU_OR, REG_B};
    localparam logic [7:0] OP_CP_HL    = {PAT_ALU_REG[7:6], ALU_CP, REG_HL_MEM};
    localparam logic [7:0] OP_ADD_IMM  = {PAT_ALU_IMM[7:6], ALU_ADD, PAT_ALU_IMM[2:0]};
    localparam logic [7:0] OP_CP_IMM   = {PAT_ALU_IMM[7:6], ALU_CP, PAT_ALU_IMM[2:0]};
    localparam logic [7:0] OP_INC_A    = PAT_INC | {2'b00, REG_A, 3'b000};
    localparam logic [7:0] OP_DEC_B    = PAT_DEC | {2'b00, REG_B, 3'b000};
    localparam logic [7:0] OP_RLCA     = PAT_ROT_A | {3'b000, 2'(SH_RLC), 3'b000};
    localparam logic [7:0] OP_RRA      = PAT_ROT_A | {3'b000, 2'(SH_RR), 3'b000};
    localparam logic [7:0] OP_ADD_HLHL = PAT_ADD_HL | {2'b00, RR_HL, 4'b0000};
    localparam logic [7:0] CB_SWAP_A   = {CB_SHIFT, SH_SWAP, REG_A};
    localparam logic [7:0] CB_BIT7_HL  = {CB_BIT, 3'd7, REG_HL_MEM};
    localparam logic [7:0] CB_RES0_HL  = {CB_RES, 3'd0, REG_HL_MEM};
    localparam logic [7:0] CB_SET7_A   = {CB_SET, 3'd7, REG_A};

    // one directed row: request, and a typed result where it is obvious
    typedef struct packed {
        req_t req;
        logic typed;
        res_t want;
    } stim_row_t;

    localparam int DIR_ROWS = 28;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{'{OP_ADD_B, 1'b0, 8'hFF, 8'h01, 4'h0, 16'h0000, 16'h0000}, 1'b1,
          '{8'h00, 16'h0000, 4'b1011, DEST_ACC, 1'b0}},
        '{'{OP_ADC_A, 1'b0, 8'h0F, 8'h00, 4'h1, 16'h1234, 16'h0000}, 1'b0, '0},
        '{'{OP_SUB_B, 1'b0, 8'h00, 8'h01, 4'h0, 16'h0000, 16'h0000}, 1'b1,
          '{8'hFF, 16'h0000, 4'b0111, DEST_ACC, 1'b0}},
        '{'{OP_SBC_B, 1'b0, 8'h10, 8'h0F, 4'h1, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{OP_AND_B, 1'b0, 8'hF0, 8'h0F, 4'h0, 16'h0000, 16'h0000}, 1'b1,
          '{8'h00, 16'h0000, 4'b1010, DEST_ACC, 1'b0}},
        '{'{OP_XOR_A, 1'b0, 8'h5A, 8'h5A, 4'h0, 16'h0000, 16'h0000}, 1'b1,
          '{8'h00, 16'h0000, 4'b1000, DEST_ACC, 1'b0}},
        '{'{OP_OR_B, 1'b0, 8'h00, 8'h80, 4'hF, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_CP_HL, 1'b0, 8'h42, 8'h42, 4'h0, 16'h0000, 16'h0000}, 1'b1,
          '{8'h42, 16'h0000, 4'b1100, DEST_FLAGS, 1'b0}},
        '{'{OP_CP_IMM, 1'b0, 8'h00, 8'hFF, 4'h0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_ADD_IMM, 1'b0, 8'h80, 8'h80, 4'h0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_INC_A, 1'b0, 8'h00, 8'hFF, 4'h1, 16'h0000, 16'h0000}, 1'b1,
          '{8'h00, 16'h0000, 4'b1011, DEST_OPERAND, 1'b0}},
        '{'{OP_DEC_B, 1'b0, 8'h00, 8'h00, 4'h0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_RLCA, 1'b0, 8'h80, 8'h00, 4'hE, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_RRA, 1'b0, 8'h01, 8'h00, 4'h0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_DAA, 1'b0, 8'h9A, 8'h00, 4'h0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_DAA, 1'b0, 8'h00, 8'h00, 4'h6, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_CPL, 1'b0, 8'h00, 8'h00, 4'h9, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_SCF, 1'b0, 8'h11, 8'h00, 4'h8, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_CCF, 1'b0, 8'h22, 8'h00, 4'h1, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_ADD_HLHL, 1'b0, 8'h00, 8'h00, 4'hF, 16'hFFFF, 16'h0001}, 1'b0, '0},
        '{'{OP_ADD_SP, 1'b0, 8'h00, 8'h80, 4'hF, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_LD_HL_SP, 1'b0, 8'h00, 8'h7F, 4'h0, 16'h00FF, 16'h0000}, 1'b0, '0},
        '{'{CB_SWAP_A, 1'b1, 8'h00, 8'hF0, 4'h0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CB_BIT7_HL, 1'b1, 8'h00, 8'h7F, 4'h1, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CB_RES0_HL, 1'b1, 8'h00, 8'hFF, 4'h0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CB_SET7_A, 1'b1, 8'h00, 8'h00, 4'hF, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{OP_NOP, 1'b0, 8'h12, 8'h34, 4'h5, 16'hABCD, 16'h0000}, 1'b1,
          '{8'h12, 16'hABCD, 4'h5, DEST_FLAGS, 1'b1}},
        '{'{OP_UNUSED, 1'b0, 8'hFF, 8'hFF, 4'hA, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_op_code;
    logic        s_cb_page;
    logic [7:0]  s_acc_in;
    logic [7:0]  s_operand_in;
    logic [3:0]  s_flags_in;
    logic [15:0] s_wide_left;
    logic [15:0] s_wide_right;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_byte_result;
    logic [15:0] m_word_result;
    logic [3:0]  m_flags_out;
    logic [1:0]  m_dest_kind;
    logic        m_not_alu_op;

    res_t expected_results [$];
    int   err_count    = 0;
    int   n_sent       = 0;
    int   n_checked    = 0;
    int   n_cb_sent    = 0;
    int   n_not_alu    = 0;
    int   cycle_count  = 0;
    logic calm         = 1'b0;
    logic squeeze_req  = 1'b0;
    logic squeeze_done = 1'b0;

    eight_bit_cpu_alu_with_flags uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op_code     (s_op_code),
        .s_cb_page     (s_cb_page),
        .s_acc_in      (s_acc_in),
        .s_operand_in  (s_operand_in),
        .s_flags_in    (s_flags_in),
        .s_wide_left   (s_wide_left),
        .s_wide_right  (s_wide_right),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_result (m_byte_result),
        .m_word_result (m_word_result),
        .m_flags_out   (m_flags_out),
        .m_dest_kind   (m_dest_kind),
        .m_not_alu_op  (m_not_alu_op)
    );

    // clock, period 8
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // rotates and shifts shared by the main and cb pages
    function automatic logic [7:0] shift_byte(input shift_kind_t kind, input logic [7:0] v,
                                              input logic cin, output logic cout);
        logic [7:0] r;
        case (kind)
            SH_RLC:  begin cout = v[7]; r = {v[6:0], v[7]}; end
            SH_RRC:  begin cout = v[0]; r = {v[0], v[7:1]}; end
            SH_RL:   begin cout = v[7]; r = {v[6:0], cin}; end
            SH_RR:   begin cout = v[0]; r = {cin, v[7:1]}; end
            SH_SLA:  begin cout = v[7]; r = {v[6:0], 1'b0}; end
            SH_SRA:  begin cout = v[0]; r = {v[7], v[7:1]}; end
            SH_SWAP: begin cout = 1'b0; r = {v[3:0], v[7:4]}; end
            default: begin cout = v[0]; r = {1'b0, v[7:1]}; end
        endcase
        return r;
    endfunction

    // expected result of one request
    function automatic res_t predict_alu(input req_t r);
        res_t        o;
        logic [7:0]  a;
        logic [7:0]  v;
        logic [7:0]  corr;
        logic [3:0]  f;
        logic [4:0]  nib;
        logic [8:0]  sum9;
        logic [12:0] sum13;
        logic [16:0] sum17;
        logic        cin;
        logic        cout;
        alu_kind_t   kind;
        a = r.acc;
        v = r.operand;
        f = r.flags;
        o.byte_result = a;
        o.word_result = r.wide_left;
        o.flags       = f;
        o.dest_kind   = DEST_FLAGS;
        o.not_alu_op  = 1'b0;
        if (r.cb_page) begin
            case (cb_group_t'(r.op_code[7:6]))
                CB_SHIFT: begin
                    o.byte_result = shift_byte(shift_kind_t'(r.op_code[5:3]), v, f[FLAG_C], cout);
                    o.flags = '0;
                    o.flags[FLAG_Z] = (o.byte_result == 8'h00);
                    o.flags[FLAG_C] = cout;
                    o.dest_kind = DEST_OPERAND;
                end
                CB_BIT: begin
                    o.byte_result = v;
                    o.flags = '0;
                    o.flags[FLAG_Z] = ~v[r.op_code[5:3]];
                    o.flags[FLAG_H] = 1'b1;
                    o.flags[FLAG_C] = f[FLAG_C];
                end
                CB_RES: begin
                    o.byte_result = v & ~(8'h01 << r.op_code[5:3]);
                    o.dest_kind = DEST_OPERAND;
                end
                default: begin
                    o.byte_result = v | (8'h01 << r.op_code[5:3]);
                    o.dest_kind = DEST_OPERAND;
                end
            endcase
        end else if ((r.op_code & MASK_ADD_HL) == PAT_ADD_HL) begin
            // add hl,rr: half carry out of bit 11, carry out of bit 15
            sum17 = {1'b0, r.wide_left} + {1'b0, r.wide_right};
            sum13 = {1'b0, r.wide_left[11:0]} + {1'b0, r.wide_right[11:0]};
            o.flags = '0;
            o.flags[FLAG_Z] = f[FLAG_Z];
            o.flags[FLAG_H] = sum13[12];
            o.flags[FLAG_C] = sum17[16];
            o.word_result = sum17[15:0];
            o.dest_kind = DEST_WIDE;
        end else if ((r.op_code & MASK_INCDEC) == PAT_INC) begin
            o.byte_result = v + 8'h01;
            o.flags = '0;
            o.flags[FLAG_Z] = (o.byte_result == 8'h00);
            o.flags[FLAG_H] = (v[3:0] == 4'hF);
            o.flags[FLAG_C] = f[FLAG_C];
            o.dest_kind = DEST_OPERAND;
        end else if ((r.op_code & MASK_INCDEC) == PAT_DEC) begin
            o.byte_result = v - 8'h01;
            o.flags = '0;
            o.flags[FLAG_Z] = (o.byte_result == 8'h00);
            o.flags[FLAG_N] = 1'b1;
            o.flags[FLAG_H] = (v[3:0] == 4'h0);
            o.flags[FLAG_C] = f[FLAG_C];
            o.dest_kind = DEST_OPERAND;
        end else if ((r.op_code & MASK_ROT_A) == PAT_ROT_A) begin
            // accumulator rotates always clear z
            o.byte_result = shift_byte(shift_kind_t'({1'b0, r.op_code[4:3]}), a, f[FLAG_C], cout);
            o.flags = '0;
            o.flags[FLAG_C] = cout;
            o.dest_kind = DEST_ACC;
        end else if (r.op_code == OP_DAA) begin
            // decimal adjust after add or subtract
            corr = 8'h00;
            o.flags = '0;
            o.flags[FLAG_N] = f[FLAG_N];
            o.flags[FLAG_C] = f[FLAG_C];
            if (f[FLAG_H] || (!f[FLAG_N] && a[3:0] > DAA_LIMIT_LO))
                corr = corr | DAA_CORR_LO;
            if (f[FLAG_C] || (!f[FLAG_N] && a > DAA_LIMIT_HI)) begin
                corr = corr | DAA_CORR_HI;
                o.flags[FLAG_C] = 1'b1;
            end
            o.byte_result = f[FLAG_N] ? a - corr : a + corr;
            o.flags[FLAG_Z] = (o.byte_result == 8'h00);
            o.dest_kind = DEST_ACC;
        end else if (r.op_code == OP_CPL) begin
            o.byte_result = ~a;
            o.flags[FLAG_N] = 1'b1;
            o.flags[FLAG_H] = 1'b1;
            o.dest_kind = DEST_ACC;
        end else if (r.op_code == OP_SCF) begin
            o.flags = '0;
            o.flags[FLAG_Z] = f[FLAG_Z];
            o.flags[FLAG_C] = 1'b1;
        end else if (r.op_code == OP_CCF) begin
            o.flags = '0;
            o.flags[FLAG_Z] = f[FLAG_Z];
            o.flags[FLAG_C] = ~f[FLAG_C];
        end else if ((r.op_code & MASK_ALU_REG) == PAT_ALU_REG ||
                     (r.op_code & MASK_INCDEC) == PAT_ALU_IMM) begin
            // 8-bit arithmetic block, register and immediate forms
            kind = alu_kind_t'(r.op_code[5:3]);
            cin = (kind == ALU_ADC || kind == ALU_SBC) ? f[FLAG_C] : 1'b0;
            o.flags = '0;
            case (kind)
                ALU_ADD, ALU_ADC: begin
                    sum9 = {1'b0, a} + {1'b0, v} + {8'd0, cin};
                    nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
                    o.flags[FLAG_H] = nib[4];
                    o.flags[FLAG_C] = sum9[8];
                end
                ALU_SUB, ALU_SBC, ALU_CP: begin
                    sum9 = {1'b0, a} - {1'b0, v} - {8'd0, cin};
                    o.flags[FLAG_N] = 1'b1;
                    o.flags[FLAG_H] = ({1'b0, a[3:0]} < {1'b0, v[3:0]} + {4'd0, cin});
                    o.flags[FLAG_C] = ({1'b0, a} < {1'b0, v} + {8'd0, cin});
                end
                ALU_AND: begin
                    sum9 = {1'b0, a & v};
                    o.flags[FLAG_H] = 1'b1;
                end
                ALU_XOR: sum9 = {1'b0, a ^ v};
                default: sum9 = {1'b0, a | v};
            endcase
            o.flags[FLAG_Z] = (sum9[7:0] == 8'h00);
            if (kind != ALU_CP) begin
                o.byte_result = sum9[7:0];
                o.dest_kind = DEST_ACC;
            end
        end else if (r.op_code == OP_ADD_SP || r.op_code == OP_LD_HL_SP) begin
            // signed offset, flags from the unsigned low byte sum
            o.word_result = r.wide_left + {{8{v[7]}}, v};
            nib = {1'b0, r.wide_left[3:0]} + {1'b0, v[3:0]};
            sum9 = {1'b0, r.wide_left[7:0]} + {1'b0, v};
            o.flags = '0;
            o.flags[FLAG_H] = nib[4];
            o.flags[FLAG_C] = sum9[8];
            o.dest_kind = DEST_WIDE;
        end else begin
            o.not_alu_op = 1'b1;
        end
        return o;
    endfunction

    // byte values biased toward carry and borrow boundaries
    function automatic logic [7:0] edgy_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h0F;
            3:       return 8'hF0;
            4:       return 8'h80;
            5:       return 8'h7F;
            6:       return 8'h99;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] edgy_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0FFF;
            3:       return 16'h00FF;
            4:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // random request, with extra weight on the single-opcode cases
    function automatic req_t random_req();
        req_t       r;
        logic [1:0] rr;
        rr = 2'($urandom_range(0, 3));
        r.cb_page = ($urandom_range(0, 2) == 0);
        r.op_code = 8'($urandom_range(0, 255));
        if (!r.cb_page && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 6))
                0:       r.op_code = OP_DAA;
                1:       r.op_code = OP_CPL;
                2:       r.op_code = OP_SCF;
                3:       r.op_code = OP_CCF;
                4:       r.op_code = OP_ADD_SP;
                5:       r.op_code = OP_LD_HL_SP;
                default: r.op_code = PAT_ADD_HL | {2'b00, rr, 4'b0000};
            endcase
        end
        r.acc        = edgy_byte();
        r.operand    = edgy_byte();
        r.flags      = 4'($urandom_range(0, 15));
        r.wide_left  = edgy_word();
        r.wide_right = edgy_word();
        return r;
    endfunction

    // offer one request, with random gaps, and log its expected result on accept
    task automatic offer_req(input req_t r, input logic typed, input res_t want);
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op_code    <= r.op_code;
        s_cb_page    <= r.cb_page;
        s_acc_in     <= r.acc;
        s_operand_in <= r.operand;
        s_flags_in   <= r.flags;
        s_wide_left  <= r.wide_left;
        s_wide_right <= r.wide_right;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(typed ? want : predict_alu(r));
        n_sent++;
        if (r.cb_page)
            n_cb_sent++;
    endtask

    task automatic report_field(input string what, input logic [15:0] want_v,
                                input logic [15:0] got_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
        err_count++;
    endtask

    // request source: reset, directed table, random requests, drain, verdict
    initial begin : request_source
        int idx;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op_code    = '0;
        s_cb_page    = 1'b0;
        s_acc_in     = '0;
        s_operand_in = '0;
        s_flags_in   = '0;
        s_wide_left  = '0;
        s_wide_right = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (idx = 0; idx < DIR_ROWS; idx++)
            offer_req(dir_rows[idx].req, dir_rows[idx].typed, dir_rows[idx].want);
        for (idx = 0; idx < RAND_ITEMS; idx++) begin
            calm = (idx >= 120 && idx < 220);
            if (idx == 300)
                squeeze_req = 1'b1;
            offer_req(random_req(), 1'b0, '0);
        end
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d requests (%0d directed, %0d random, %0d on the cb page)",
                 n_sent, DIR_ROWS, RAND_ITEMS, n_cb_sent);
        $display("%0d results checked, %0d non-alu opcodes, one %0d-cycle output hold, %0d errors",
                 n_checked, n_not_alu, HOLD_CYCLES, err_count);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // result sink: random stalls, one long hold while requests keep coming
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending, byte %0h word %0h flags %0h",
                         $time, m_byte_result, m_word_result, m_flags_out);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (m_not_alu_op)
                    n_not_alu++;
                if (m_byte_result !== want.byte_result)
                    report_field("byte_result", 16'(want.byte_result), 16'(m_byte_result));
                if (m_word_result !== want.word_result)
                    report_field("word_result", want.word_result, m_word_result);
                if (m_flags_out !== want.flags)
                    report_field("flags_out", 16'(want.flags), 16'(m_flags_out));
                if (m_dest_kind !== want.dest_kind)
                    report_field("dest_kind", 16'(want.dest_kind), 16'(m_dest_kind));
                if (m_not_alu_op !== want.not_alu_op)
                    report_field("not_alu_op", 16'(want.not_alu_op), 16'(m_not_alu_op));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= WATCHDOG_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
